// ----- sv/log_line_keyword_classifier_macros.svh -----
// Assertion macros shared by the keyword classifier modules
`ifndef LOG_LINE_KEYWORD_CLASSIFIER_MACROS_SVH
`define LOG_LINE_KEYWORD_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LLKC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LLKC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/llkc_pkg.sv -----
// Types, keyword constants and match functions of the keyword classifier
`default_nettype none

package llkc_pkg;

  localparam int HIST_DEPTH    = 17;
  localparam int WIN_BYTES     = HIST_DEPTH + 1;
  localparam int FLAG_COUNT    = 6;
  localparam int COUNTER_COUNT = 8;
  localparam int CNT_OUT_BITS  = 32;

  typedef logic [7:0]             byte_t;
  typedef logic [WIN_BYTES*8-1:0] window_t;
  typedef logic [HIST_DEPTH*8-1:0] history_t;
  typedef logic [FLAG_COUNT-1:0]  flags_t;
  typedef logic [1:0]             class_t;
  typedef logic [CNT_OUT_BITS-1:0] count_out_t;

  typedef struct packed {
    logic   valid;
    flags_t flags;
  } line_rec_t;

  localparam class_t CLS_ERROR   = 2'd0;
  localparam class_t CLS_WARNING = 2'd1;
  localparam class_t CLS_INFO    = 2'd2;
  localparam class_t CLS_OTHER   = 2'd3;

  localparam int FLG_ERROR   = 0;
  localparam int FLG_WARN    = 1;
  localparam int FLG_INFO    = 2;
  localparam int FLG_TIMEOUT = 3;
  localparam int FLG_REFUSED = 4;
  localparam int FLG_LOGIN   = 5;

  localparam int CNT_LINES   = 0;
  localparam int CNT_ERROR   = 1;
  localparam int CNT_WARNING = 2;
  localparam int CNT_INFO    = 3;
  localparam int CNT_OTHER   = 4;
  localparam int CNT_TIMEOUT = 5;
  localparam int CNT_REFUSED = 6;
  localparam int CNT_LOGIN   = 7;

  // last character in the low byte, zero padded above
  localparam window_t KW_ERROR    = "ERROR";
  localparam window_t KW_FAIL     = "FAIL";
  localparam window_t KW_CRITICAL = "CRITICAL";
  localparam window_t KW_WARN     = "WARN";
  localparam window_t KW_INFO     = "INFO";
  localparam window_t KW_DEBUG    = "DEBUG";
  localparam window_t KW_TIMEOUT  = "timeout";
  localparam window_t KW_REFUSED  = "connection refused";
  localparam window_t KW_LOGIN    = "failed login";

  localparam int KW_ERROR_LEN    = 5;
  localparam int KW_FAIL_LEN     = 4;
  localparam int KW_CRITICAL_LEN = 8;
  localparam int KW_WARN_LEN     = 4;
  localparam int KW_INFO_LEN     = 4;
  localparam int KW_DEBUG_LEN    = 5;
  localparam int KW_TIMEOUT_LEN  = 7;
  localparam int KW_REFUSED_LEN  = 18;
  localparam int KW_LOGIN_LEN    = 12;

  localparam byte_t CHAR_LOWER_A = 8'h61;
  localparam byte_t CHAR_LOWER_Z = 8'h7a;
  localparam byte_t CASE_OFFSET  = 8'h20;

  function automatic byte_t fold_upper(input byte_t c);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  // window byte 0 is the current byte, byte k the one k places before it
  function automatic logic kw_hit(input window_t win, input window_t pat,
                                  input int len, input logic fold);
    logic  hit;
    byte_t w;
    hit = 1'b1;
    for (int k = 0; k < WIN_BYTES; k++) begin
      w = fold ? fold_upper(win[8*k +: 8]) : win[8*k +: 8];
      if (k < len && w != pat[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic flags_t scan_window(input window_t win);
    flags_t hits;
    hits = '0;
    hits[FLG_ERROR]   = kw_hit(win, KW_ERROR, KW_ERROR_LEN, 1'b1)
                      | kw_hit(win, KW_FAIL, KW_FAIL_LEN, 1'b1)
                      | kw_hit(win, KW_CRITICAL, KW_CRITICAL_LEN, 1'b1);
    hits[FLG_WARN]    = kw_hit(win, KW_WARN, KW_WARN_LEN, 1'b1);
    hits[FLG_INFO]    = kw_hit(win, KW_INFO, KW_INFO_LEN, 1'b1)
                      | kw_hit(win, KW_DEBUG, KW_DEBUG_LEN, 1'b1);
    hits[FLG_TIMEOUT] = kw_hit(win, KW_TIMEOUT, KW_TIMEOUT_LEN, 1'b0);
    hits[FLG_REFUSED] = kw_hit(win, KW_REFUSED, KW_REFUSED_LEN, 1'b0);
    hits[FLG_LOGIN]   = kw_hit(win, KW_LOGIN, KW_LOGIN_LEN, 1'b0);
    return hits;
  endfunction

endpackage

`default_nettype wire

// ----- sv/llkc_matcher.sv -----
// Input register, byte history and per-line keyword flags
`default_nettype none
`include "log_line_keyword_classifier_macros.svh"

module llkc_matcher (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  llkc_pkg::byte_t   text_byte,
  input  logic              byte_present,
  input  logic              line_end,
  output llkc_pkg::line_rec_t rec,
  input  logic              rec_take
);
  import llkc_pkg::*;

  logic     iv;
  byte_t    ibyte;
  logic     ipres;
  logic     iend;
  history_t history;
  flags_t   flags;
  flags_t   flags_next;
  window_t  window;
  logic     rec_free;
  logic     i_move;

  assign rec_free   = !rec.valid || rec_take;
  assign i_move     = iv && (!iend || rec_free);
  assign in_stall   = iv && !i_move;
  assign window     = {history, ibyte};
  assign flags_next = flags | (ipres ? scan_window(window) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv        <= 1'b0;
      history   <= '0;
      flags     <= '0;
      rec.valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        iv <= in_valid;
      end
      if (i_move) begin
        if (iend) begin
          history <= '0;
          flags   <= '0;
        end else if (ipres) begin
          history <= {history[HIST_DEPTH*8-9:0], ibyte};
          flags   <= flags_next;
        end
      end
      if (i_move && iend) begin
        rec.valid <= 1'b1;
        rec.flags <= flags_next;
      end else if (rec_take) begin
        rec.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ibyte <= text_byte;
      ipres <= byte_present;
      iend  <= line_end;
    end
  end

  `LLKC_ASSERT_IMP(a_stall_only_on_end, in_stall, iv && iend, "stall without held line end")
  `LLKC_ASSERT_NXT(a_end_makes_rec, i_move && iend, rec.valid, "line end lost")
  `LLKC_ASSERT_NXT(a_end_clears_flags, i_move && iend, flags == '0, "flags not cleared")

endmodule

`default_nettype wire

// ----- sv/llkc_tally.sv -----
// Line classification, saturating counters and result register
`default_nettype none
`include "log_line_keyword_classifier_macros.svh"

module llkc_tally #(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  llkc_pkg::line_rec_t  rec,
  output logic                 rec_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output llkc_pkg::class_t     line_class,
  output logic                 timeout_seen,
  output logic                 refused_seen,
  output logic                 login_fail_seen,
  output llkc_pkg::count_out_t count_out [llkc_pkg::COUNTER_COUNT]
);
  import llkc_pkg::*;

  logic [COUNT_BITS-1:0]    counts [COUNTER_COUNT];
  class_t                   cls;
  logic [COUNTER_COUNT-1:0] inc;

  assign rec_take = rec.valid && (!out_valid || !out_stall);

  always_comb begin
    if (rec.flags[FLG_ERROR]) begin
      cls = CLS_ERROR;
    end else if (rec.flags[FLG_WARN]) begin
      cls = CLS_WARNING;
    end else if (rec.flags[FLG_INFO]) begin
      cls = CLS_INFO;
    end else begin
      cls = CLS_OTHER;
    end
    inc              = '0;
    inc[CNT_LINES]   = 1'b1;
    inc[CNT_ERROR]   = (cls == CLS_ERROR);
    inc[CNT_WARNING] = (cls == CLS_WARNING);
    inc[CNT_INFO]    = (cls == CLS_INFO);
    inc[CNT_OTHER]   = (cls == CLS_OTHER);
    inc[CNT_TIMEOUT] = rec.flags[FLG_TIMEOUT];
    inc[CNT_REFUSED] = rec.flags[FLG_REFUSED];
    inc[CNT_LOGIN]   = rec.flags[FLG_LOGIN];
  end

  always_comb begin
    for (int i = 0; i < COUNTER_COUNT; i++) begin
      count_out[i] = CNT_OUT_BITS'(counts[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < COUNTER_COUNT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (rec_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      for (int i = 0; i < COUNTER_COUNT; i++) begin
        if (rec_take && inc[i] && counts[i] != '1) begin
          counts[i] <= counts[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      line_class      <= cls;
      timeout_seen    <= rec.flags[FLG_TIMEOUT];
      refused_seen    <= rec.flags[FLG_REFUSED];
      login_fail_seen <= rec.flags[FLG_LOGIN];
    end
  end

  `LLKC_ASSERT_NXT(a_take_loads_out, rec_take, out_valid, "result not loaded")
  `LLKC_ASSERT_NXT(a_hold_counts, out_valid && out_stall, $stable(counts[CNT_LINES]), "count moved under stall")
  `LLKC_ASSERT_NXT(a_lines_nonzero, rec_take, counts[CNT_LINES] != '0, "line count not bumped")

endmodule

`default_nettype wire

// ----- sv/log_line_keyword_classifier.sv -----
// Log line keyword classifier: top level
// Input channel: in_valid / in_stall carry one request per cycle, unless
// stalled, with text_byte, byte_present and line_end. byte_present low
// with line_end low is an idle request; byte_present low with line_end high
// ends a line with no byte. Keywords are matched against an 18-byte window
// (current byte and 17 before it) held in registers, so every cycle can take
// a new byte. Output channel: out_valid / out_stall carry one result per
// finished line: class, three keyword flags and eight running line counts.
// Path: a line-end request goes from the input register to the line record,
// then to the result register. Throughput: one request per cycle unless
// stalled, set by the single window compare stage; the result register lets
// input flow on while a result waits.
// Stall: when the result register and the line record both hold unaccepted
// lines, in_stall rises only when a further line end is pending; plain
// bytes keep flowing.
// Reset clears the byte history, flags and all counters (COUNT_BITS wide,
// saturating, low 32 bits shown).
`default_nettype none

module log_line_keyword_classifier #(
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  llkc_pkg::byte_t        text_byte,
  input  logic                   byte_present,
  input  logic                   line_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output llkc_pkg::class_t       line_class,
  output logic                   timeout_seen,
  output logic                   refused_seen,
  output logic                   login_fail_seen,
  output llkc_pkg::count_out_t   lines_total,
  output llkc_pkg::count_out_t   error_lines,
  output llkc_pkg::count_out_t   warning_lines,
  output llkc_pkg::count_out_t   info_lines,
  output llkc_pkg::count_out_t   other_lines,
  output llkc_pkg::count_out_t   timeout_lines,
  output llkc_pkg::count_out_t   refused_lines,
  output llkc_pkg::count_out_t   login_fail_lines
);
  import llkc_pkg::*;

  line_rec_t  rec;
  logic       rec_take;
  count_out_t count_out [COUNTER_COUNT];

  llkc_matcher u_matcher (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .line_end     (line_end),
    .rec          (rec),
    .rec_take     (rec_take)
  );

  llkc_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk             (clk),
    .rst             (rst),
    .rec             (rec),
    .rec_take        (rec_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_class      (line_class),
    .timeout_seen    (timeout_seen),
    .refused_seen    (refused_seen),
    .login_fail_seen (login_fail_seen),
    .count_out       (count_out)
  );

  assign lines_total      = count_out[CNT_LINES];
  assign error_lines      = count_out[CNT_ERROR];
  assign warning_lines    = count_out[CNT_WARNING];
  assign info_lines       = count_out[CNT_INFO];
  assign other_lines      = count_out[CNT_OTHER];
  assign timeout_lines    = count_out[CNT_TIMEOUT];
  assign refused_lines    = count_out[CNT_REFUSED];
  assign login_fail_lines = count_out[CNT_LOGIN];

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking keyword classifier bench: directed lines, held output, then random text
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llkc_pkg::*;

  localparam int DIRECTED_ROWS = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [63:0] text;
    logic [3:0]  len;
    logic        gap;
    logic        end_alone;
    logic        typed;
    class_t      cls;
    logic [2:0]  kw;
  } line_row_t;

  typedef struct packed {
    class_t cls;
    logic   timeout_hit;
    logic   refused_hit;
    logic   login_hit;
    logic [COUNTER_COUNT-1:0][CNT_OUT_BITS-1:0] counts;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  byte_t      text_byte;
  logic       byte_present;
  logic       line_end;
  logic       out_valid;
  logic       out_stall;
  class_t     line_class;
  logic       timeout_seen;
  logic       refused_seen;
  logic       login_fail_seen;
  count_out_t lines_total;
  count_out_t error_lines;
  count_out_t warning_lines;
  count_out_t info_lines;
  count_out_t other_lines;
  count_out_t timeout_lines;
  count_out_t refused_lines;
  count_out_t login_fail_lines;

  logic [COUNTER_COUNT-1:0][CNT_OUT_BITS-1:0] seen_counts;

  byte_t  recent [HIST_DEPTH];
  int     fill;
  flags_t line_flags;
  logic [COUNTER_COUNT-1:0][CNT_OUT_BITS-1:0] line_counts;

  line_result_t expected_lines [$];
  line_result_t oldest_line;
  line_row_t    directed_rows [DIRECTED_ROWS];

  logic       typed_armed;
  class_t     typed_cls;
  logic [2:0] typed_kw;

  int    idle_pct;
  int    stall_pct;
  int    hold_left;
  bit    hold_request;
  int    requests_sent;
  int    mismatches;
  string filler_chars = "eRrOfAiLcTwNdBgUmSo nIKlpq:.-0";

  log_line_keyword_classifier i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .text_byte        (text_byte),
    .byte_present     (byte_present),
    .line_end         (line_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .line_class       (line_class),
    .timeout_seen     (timeout_seen),
    .refused_seen     (refused_seen),
    .login_fail_seen  (login_fail_seen),
    .lines_total      (lines_total),
    .error_lines      (error_lines),
    .warning_lines    (warning_lines),
    .info_lines       (info_lines),
    .other_lines      (other_lines),
    .timeout_lines    (timeout_lines),
    .refused_lines    (refused_lines),
    .login_fail_lines (login_fail_lines)
  );

  assign seen_counts = {login_fail_lines, refused_lines, timeout_lines, other_lines,
                        info_lines, warning_lines, error_lines, lines_total};

  always #4 clk = ~clk;

  function automatic string pattern_text(int idx);
    case (idx)
      0: return "error";
      1: return "fail";
      2: return "critical";
      3: return "warn";
      4: return "info";
      5: return "debug";
      6: return "timeout";
      7: return "connection refused";
      default: return "failed login";
    endcase
  endfunction

  function automatic int pattern_flag(int idx);
    case (idx)
      0, 1, 2: return FLG_ERROR;
      3:       return FLG_WARN;
      4, 5:    return FLG_INFO;
      6:       return FLG_TIMEOUT;
      7:       return FLG_REFUSED;
      default: return FLG_LOGIN;
    endcase
  endfunction

  function automatic bit pattern_folds(int idx);
    return idx < 6;
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic byte_t upcase(byte_t c);
    return (c >= "a" && c <= "z") ? (c & 8'hdf) : c;
  endfunction

  function automatic byte_t flip_case(byte_t c);
    return ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) ? (c ^ 8'h20) : c;
  endfunction

  function automatic bit word_ends_here(int idx, byte_t cur);
    string w;
    int    n;
    byte_t got;
    byte_t ref_char;
    w = pattern_text(idx);
    n = w.len();
    if (fill < n - 1) return 1'b0;
    for (int k = 0; k < n; k++) begin
      got = (k == 0) ? cur : recent[k-1];
      ref_char = w[n-1-k];
      if (pattern_folds(idx) ? (upcase(got) != upcase(ref_char)) : (got != ref_char))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_line_state();
    for (int k = 0; k < HIST_DEPTH; k++) recent[k] = '0;
    fill = 0;
    line_flags = '0;
  endtask

  task automatic classify_request(byte_t b, logic present, logic end_mark);
    line_result_t       res;
    class_t             cls;
    logic [COUNTER_COUNT-1:0] bump_mask;
    if (present) begin
      for (int p = 0; p < 9; p++)
        if (word_ends_here(p, b)) line_flags[pattern_flag(p)] = 1'b1;
      for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (fill < HIST_DEPTH) fill++;
    end
    if (end_mark) begin
      if (line_flags[FLG_ERROR]) cls = CLS_ERROR;
      else if (line_flags[FLG_WARN]) cls = CLS_WARNING;
      else if (line_flags[FLG_INFO]) cls = CLS_INFO;
      else cls = CLS_OTHER;
      bump_mask = '0;
      bump_mask[CNT_LINES] = 1'b1;
      bump_mask[CNT_ERROR + int'(cls)] = 1'b1;
      bump_mask[CNT_TIMEOUT] = line_flags[FLG_TIMEOUT];
      bump_mask[CNT_REFUSED] = line_flags[FLG_REFUSED];
      bump_mask[CNT_LOGIN] = line_flags[FLG_LOGIN];
      for (int c = 0; c < COUNTER_COUNT; c++)
        if (bump_mask[c] && line_counts[c] != '1) line_counts[c] = line_counts[c] + 1'b1;
      res.cls = cls;
      res.timeout_hit = line_flags[FLG_TIMEOUT];
      res.refused_hit = line_flags[FLG_REFUSED];
      res.login_hit = line_flags[FLG_LOGIN];
      res.counts = line_counts;
      if (typed_armed) begin
        res.cls = typed_cls;
        {res.timeout_hit, res.refused_hit, res.login_hit} = typed_kw;
        typed_armed = 1'b0;
      end
      expected_lines = {expected_lines, res};
      clear_line_state();
    end
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic send_request(byte_t b, logic present, logic end_mark);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    text_byte    <= b;
    byte_present <= present;
    line_end     <= end_mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    classify_request(b, present, end_mark);
    if (present || end_mark) requests_sent++;
  endtask

  task automatic send_random_line(int segs_max);
    byte_t line_q [$];
    string w;
    int    segs;
    int    idx;
    int    n;
    int    pick;
    bit    fold;
    byte_t c;
    segs = $urandom_range(0, segs_max);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(0, 2) != 0) begin
        idx  = $urandom_range(0, 9);
        w    = (idx == 9) ? "warning" : pattern_text(idx);
        fold = (idx == 9) || pattern_folds(idx);
        n    = w.len();
        if ($urandom_range(0, 7) == 0) n--;
        pick = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
          c = w[k];
          if (fold ? $urandom_range(0, 1) == 1 : (k == pick && $urandom_range(0, 3) == 0))
            c = flip_case(c);
          line_q = {line_q, c};
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 1) c = rand_byte();
          else c = filler_chars[$urandom_range(0, filler_chars.len() - 1)];
          line_q = {line_q, c};
        end
      end
    end
    if (line_q.size() == 0 || $urandom_range(0, 3) == 0) begin
      foreach (line_q[i]) begin
        if ($urandom_range(0, 11) == 0) send_request(rand_byte(), 1'b0, 1'b0);
        send_request(line_q[i], 1'b1, 1'b0);
      end
      send_request(rand_byte(), 1'b0, 1'b1);
    end else begin
      foreach (line_q[i]) begin
        if ($urandom_range(0, 11) == 0) send_request(rand_byte(), 1'b0, 1'b0);
        send_request(line_q[i], 1'b1, i == line_q.size() - 1);
      end
    end
  endtask

  task automatic drain_lines();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        note_mismatch("result with no line pending");
      end else begin
        oldest_line = expected_lines.pop_front();
        if (line_class !== oldest_line.cls)
          note_mismatch($sformatf("line_class got %0d want %0d", line_class, oldest_line.cls));
        if (timeout_seen !== oldest_line.timeout_hit)
          note_mismatch($sformatf("timeout_seen got %b", timeout_seen));
        if (refused_seen !== oldest_line.refused_hit)
          note_mismatch($sformatf("refused_seen got %b", refused_seen));
        if (login_fail_seen !== oldest_line.login_hit)
          note_mismatch($sformatf("login_fail_seen got %b", login_fail_seen));
        for (int c = 0; c < COUNTER_COUNT; c++)
          if (seen_counts[c] !== oldest_line.counts[c])
            note_mismatch($sformatf("count %0d got %0d want %0d", c, seen_counts[c],
                                    oldest_line.counts[c]));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    line_row_t row;
    bit        last;
    int        goal;
    rst          = 1'b1;
    in_valid     = 1'b0;
    text_byte    = '0;
    byte_present = 1'b0;
    line_end     = 1'b0;
    out_stall    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_left    = 0;
    hold_request = 1'b0;
    typed_armed  = 1'b0;
    typed_cls    = CLS_OTHER;
    typed_kw     = '0;
    requests_sent = 0;
    mismatches   = 0;
    line_counts  = '0;
    clear_line_state();

    directed_rows[0] = '{64'd0, 4'd0, 1'b0, 1'b1, 1'b1, CLS_OTHER, 3'b000};
    directed_rows[1] = '{"Error", 4'd5, 1'b0, 1'b0, 1'b1, CLS_ERROR, 3'b000};
    directed_rows[2] = '{"wArN", 4'd4, 1'b1, 1'b1, 1'b1, CLS_WARNING, 3'b000};
    directed_rows[3] = '{64'hff00, 4'd2, 1'b0, 1'b0, 1'b1, CLS_OTHER, 3'b000};
    directed_rows[4] = '{{8'hc9, "NFO"}, 4'd4, 1'b0, 1'b0, 1'b1, CLS_OTHER, 3'b000};
    directed_rows[5] = '{"ERR", 4'd3, 1'b0, 1'b0, 1'b1, CLS_OTHER, 3'b000};
    directed_rows[6] = '{"OR", 4'd2, 1'b0, 1'b0, 1'b1, CLS_OTHER, 3'b000};
    directed_rows[7] = '{"dEbUg", 4'd5, 1'b1, 1'b0, 1'b0, CLS_OTHER, 3'b000};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      for (int i = 0; i < row.len; i++) begin
        if (row.gap && i == 1) send_request(rand_byte(), 1'b0, 1'b0);
        last = (i == row.len - 1) && !row.end_alone;
        if (last) begin
          typed_armed = row.typed;
          typed_cls   = row.cls;
          typed_kw    = row.kw;
        end
        send_request(row.text[8*(row.len-1-i) +: 8], 1'b1, last);
      end
      if (row.end_alone) begin
        typed_armed = row.typed;
        typed_cls   = row.cls;
        typed_kw    = row.kw;
        send_request(rand_byte(), 1'b0, 1'b1);
      end
    end
    drain_lines();

    // hold the result side while short lines keep arriving
    hold_request = 1'b1;
    repeat (50) begin
      send_request(rand_byte(), 1'b1, 1'b0);
      send_request(rand_byte(), 1'b1, 1'b1);
    end
    drain_lines();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      goal = requests_sent + 100;
      while (requests_sent < goal) begin
        if ($urandom_range(0, 9) == 0) send_request(rand_byte(), 1'b0, 1'b0);
        send_random_line(3);
      end
      drain_lines();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
